// ===== rtl/core/tpe_pkg.sv =====
// shared constants, types and helpers of the trajectory polynomial evaluator
package tpe_pkg;

	localparam int SEGMENTS   = 16;
	localparam int COEFFS     = 8;
	localparam int NUM_AXES   = 3;
	localparam int NUM_DER    = 3;
	localparam int VAL_W      = 48;
	localparam int TIME_W     = 24;
	localparam int SEG_W      = 4;
	localparam int AXIS_W     = 2;
	localparam int POW_W      = 3;
	localparam int FRAC_SHIFT = 16;
	localparam int SPLIT      = 24;
	localparam int HI_W       = VAL_W - SPLIT + TIME_W + 1;
	localparam int LO_W       = SPLIT + TIME_W;
	localparam int PROD_W     = VAL_W + TIME_W + 1;
	localparam int SUM_W      = PROD_W - FRAC_SHIFT + 1;
	localparam int CIDX_W     = (COEFFS > 1) ? $clog2(COEFFS) : 1;
	localparam int W_W        = $clog2(COEFFS * COEFFS);
	localparam int WC_W       = VAL_W + W_W + 1;
	localparam int DEPTH      = SEGMENTS * NUM_AXES * COEFFS;
	localparam int ADDR_W     = $clog2(DEPTH);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_RESULT
	} ctl_state_t;

	typedef struct packed {
		logic              wr_en;
		logic              capture;
		logic              rd_en;
		logic [AXIS_W-1:0] rd_axis;
		logic [CIDX_W-1:0] rd_j;
		logic              load;
	} dp_cmd_t;

	typedef struct packed {
		logic seg_ok;
		logic busy;
	} dp_stat_t;

	// derivative weight: 1, j or j*(j-1)
	function automatic logic [W_W-1:0] weight(input int d, input logic [CIDX_W-1:0] j);
		int jj;
		jj = int'(j);
		if (d == 0) begin
			return W_W'(1);
		end else if (d == 1) begin
			return W_W'(jj);
		end else begin
			return W_W'(jj * (jj - 1));
		end
	endfunction

endpackage

// ===== rtl/core/tpe_req_if.sv =====
// request channel of the trajectory polynomial evaluator
interface tpe_req_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [tpe_pkg::SEG_W-1:0]         segment;
	logic [tpe_pkg::AXIS_W-1:0]        axis;
	logic [tpe_pkg::POW_W-1:0]         power;
	logic signed [tpe_pkg::VAL_W-1:0]  coeff_value;
	logic [tpe_pkg::TIME_W-1:0]        time_value;

	modport source (
		output valid, req_type, segment, axis, power, coeff_value, time_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, segment, axis, power, coeff_value, time_value,
		output ready
	);
endinterface

// ===== rtl/core/tpe_res_if.sv =====
// result channel of the trajectory polynomial evaluator
interface tpe_res_if;
	logic                 valid;
	logic                 ready;
	tpe_pkg::val_t        pos_x;
	tpe_pkg::val_t        pos_y;
	tpe_pkg::val_t        pos_z;
	tpe_pkg::val_t        vel_x;
	tpe_pkg::val_t        vel_y;
	tpe_pkg::val_t        vel_z;
	tpe_pkg::val_t        acc_x;
	tpe_pkg::val_t        acc_y;
	tpe_pkg::val_t        acc_z;
	logic                 saturated;

	modport source (
		output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		       acc_x, acc_y, acc_z, saturated,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		       acc_x, acc_y, acc_z, saturated,
		output ready
	);
endinterface

// ===== rtl/core/trajectory_polynomial_evaluator.sv =====
// top level of the trajectory polynomial evaluator
//
//   channel | dir | moves                                    | accepted when
//   req     | in  | coefficient write or evaluate request    | req.valid && req.ready
//   res     | out | pos/vel/acc on x, y, z and clamp flag    | res.valid && res.ready
//
// a coefficient write is taken in idle and gives no result.
// an evaluate reads the 24 coefficients of its segment, one a cycle through the
// single store read port, into a two-stage horner pipeline; the result is
// registered once the pipeline has drained and the result register is free, and the next request is taken after that.
// an evaluate of a segment beyond the table skips the reads and returns zeros.
// a waiting result does not block a new request; the store is not cleared by reset.
module trajectory_polynomial_evaluator (
	input  logic     clk,
	input  logic     arst_n,
	tpe_req_if.sink  req,
	tpe_res_if.source res
);

	tpe_pkg::dp_cmd_t   cmd;
	tpe_pkg::dp_stat_t  stat;
	tpe_pkg::val_t      res_val [tpe_pkg::NUM_DER][tpe_pkg::NUM_AXES];
	logic               res_sat;

	tpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tpe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.segment     (req.segment),
		.axis        (req.axis),
		.power       (req.power),
		.coeff_value (req.coeff_value),
		.time_value  (req.time_value),
		.res_val     (res_val),
		.res_sat     (res_sat)
	);

	assign res.pos_x     = res_val[0][0];
	assign res.pos_y     = res_val[0][1];
	assign res.pos_z     = res_val[0][2];
	assign res.vel_x     = res_val[1][0];
	assign res.vel_y     = res_val[1][1];
	assign res.vel_z     = res_val[1][2];
	assign res.acc_x     = res_val[2][0];
	assign res.acc_y     = res_val[2][1];
	assign res.acc_z     = res_val[2][2];
	assign res.saturated = res_sat;

endmodule

// ===== rtl/core/tpe_ctrl.sv =====
// sequencer: request handshake, coefficient read order, result handshake
module tpe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_type,
	output logic               req_ready,
	output logic               res_valid,
	input  logic               res_ready,
	output tpe_pkg::dp_cmd_t   cmd,
	input  tpe_pkg::dp_stat_t  stat
);

	tpe_pkg::ctl_state_t                 state_q, state_d;
	logic [tpe_pkg::AXIS_W-1:0]          axis_q;
	logic [tpe_pkg::CIDX_W-1:0]          j_q;
	logic                                res_valid_q;
	logic                                last_read;
	logic                                out_free;

	assign last_read = (int'(axis_q) == tpe_pkg::NUM_AXES - 1) && (j_q == '0);
	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tpe_pkg::ST_IDLE: begin
				if (req_valid && req_type == tpe_pkg::REQ_EVAL) begin
					state_d = stat.seg_ok ? tpe_pkg::ST_READ : tpe_pkg::ST_RESULT;
				end
			end
			tpe_pkg::ST_READ: begin
				if (last_read) begin
					state_d = tpe_pkg::ST_DRAIN;
				end
			end
			tpe_pkg::ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = tpe_pkg::ST_RESULT;
				end
			end
			tpe_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = tpe_pkg::ST_IDLE;
				end
			end
			default: state_d = tpe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			tpe_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.wr_en   = req_valid && req_type == tpe_pkg::REQ_WRITE;
				cmd.capture = req_valid && req_type == tpe_pkg::REQ_EVAL;
			end
			tpe_pkg::ST_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_axis = axis_q;
				cmd.rd_j    = j_q;
			end
			tpe_pkg::ST_DRAIN: begin
				cmd.rd_en = 1'b0;
			end
			tpe_pkg::ST_RESULT: begin
				cmd.load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpe_pkg::ST_IDLE;
			axis_q      <= '0;
			j_q         <= tpe_pkg::CIDX_W'(tpe_pkg::COEFFS - 1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// walk x, y, z for each power, highest power first
			if (state_q == tpe_pkg::ST_READ) begin
				if (int'(axis_q) == tpe_pkg::NUM_AXES - 1) begin
					axis_q <= '0;
					j_q    <= j_q - 1'b1;
				end else begin
					axis_q <= axis_q + 1'b1;
				end
			end else begin
				axis_q <= '0;
				j_q    <= tpe_pkg::CIDX_W'(tpe_pkg::COEFFS - 1);
			end
			if (cmd.load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/tpe_dp.sv =====
// datapath: coefficient store, three horner lanes, result register
module tpe_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tpe_pkg::dp_cmd_t                 cmd,
	output tpe_pkg::dp_stat_t                stat,
	input  logic [tpe_pkg::SEG_W-1:0]        segment,
	input  logic [tpe_pkg::AXIS_W-1:0]       axis,
	input  logic [tpe_pkg::POW_W-1:0]        power,
	input  tpe_pkg::val_t                    coeff_value,
	input  logic [tpe_pkg::TIME_W-1:0]       time_value,
	output tpe_pkg::val_t                    res_val [tpe_pkg::NUM_DER][tpe_pkg::NUM_AXES],
	output logic                             res_sat
);

	logic [tpe_pkg::VAL_W-1:0]            mem [tpe_pkg::DEPTH];
	logic [tpe_pkg::ADDR_W-1:0]           waddr, raddr;
	logic                                 wr_ok;

	logic [tpe_pkg::SEG_W-1:0]            seg_q;
	logic [tpe_pkg::TIME_W-1:0]           time_q;

	// stage 1: coefficient out of the store
	logic                                 vld_s1;
	logic [tpe_pkg::AXIS_W-1:0]           axis_s1;
	logic [tpe_pkg::CIDX_W-1:0]           j_s1;
	tpe_pkg::val_t                        coef_s1;

	// stage 2: partial products and weighted coefficient
	logic                                 vld_s2;
	logic [tpe_pkg::AXIS_W-1:0]           axis_s2;
	logic [tpe_pkg::CIDX_W-1:0]           j_s2;
	logic signed [tpe_pkg::HI_W-1:0]      hi_s2 [tpe_pkg::NUM_DER];
	logic [tpe_pkg::LO_W-1:0]             lo_s2 [tpe_pkg::NUM_DER];
	logic signed [tpe_pkg::WC_W-1:0]      wc_s2 [tpe_pkg::NUM_DER];

	logic signed [tpe_pkg::HI_W-1:0]      hi_c  [tpe_pkg::NUM_DER];
	logic [tpe_pkg::LO_W-1:0]             lo_c  [tpe_pkg::NUM_DER];
	logic signed [tpe_pkg::WC_W-1:0]      wc_c  [tpe_pkg::NUM_DER];
	tpe_pkg::val_t                        cur_c [tpe_pkg::NUM_DER];

	logic signed [tpe_pkg::PROD_W-1:0]    full_c [tpe_pkg::NUM_DER];
	logic signed [tpe_pkg::SUM_W-1:0]     sum_c  [tpe_pkg::NUM_DER];
	tpe_pkg::val_t                        new_c  [tpe_pkg::NUM_DER];
	logic [tpe_pkg::NUM_DER-1:0]          clamp_c;
	logic [tpe_pkg::NUM_DER-1:0]          en_c;

	tpe_pkg::val_t                        acc_q [tpe_pkg::NUM_DER][tpe_pkg::NUM_AXES];
	logic                                 sat_q;
	tpe_pkg::val_t                        res_q [tpe_pkg::NUM_DER][tpe_pkg::NUM_AXES];
	logic                                 res_sat_q;

	assign wr_ok = (int'(segment) < tpe_pkg::SEGMENTS) && (int'(axis) < tpe_pkg::NUM_AXES)
		&& (int'(power) < tpe_pkg::COEFFS);
	assign waddr = tpe_pkg::ADDR_W'((int'(segment) * tpe_pkg::NUM_AXES + int'(axis))
		* tpe_pkg::COEFFS + int'(power));
	assign raddr = tpe_pkg::ADDR_W'((int'(seg_q) * tpe_pkg::NUM_AXES + int'(cmd.rd_axis))
		* tpe_pkg::COEFFS + int'(cmd.rd_j));

	assign stat.seg_ok = int'(segment) < tpe_pkg::SEGMENTS;
	assign stat.busy   = vld_s1 || vld_s2;

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[waddr] <= coeff_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			coef_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1 logic: multiply both 24-bit halves of acc by t, and weight the coefficient
	always_comb begin
		for (int d = 0; d < tpe_pkg::NUM_DER; d++) begin
			cur_c[d] = acc_q[d][axis_s1];
			hi_c[d]  = $signed(cur_c[d][tpe_pkg::VAL_W-1:tpe_pkg::SPLIT])
				* $signed({1'b0, time_q});
			lo_c[d]  = cur_c[d][tpe_pkg::SPLIT-1:0] * time_q;
			wc_c[d]  = coef_s1 * $signed({1'b0, tpe_pkg::weight(d, j_s1)});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seg_q  <= segment;
			time_q <= time_value;
		end
		if (cmd.rd_en) begin
			axis_s1 <= cmd.rd_axis;
			j_s1    <= cmd.rd_j;
		end
		axis_s2 <= axis_s1;
		j_s2    <= j_s1;
		for (int d = 0; d < tpe_pkg::NUM_DER; d++) begin
			hi_s2[d] <= hi_c[d];
			lo_s2[d] <= lo_c[d];
			wc_s2[d] <= wc_c[d];
		end
	end

	// stage 2 logic: floor(acc * t / 2^16) + w * c, clamped to 48 bits
	always_comb begin
		for (int d = 0; d < tpe_pkg::NUM_DER; d++) begin
			full_c[d] = $signed({hi_s2[d], {tpe_pkg::SPLIT{1'b0}}})
				+ $signed({{(tpe_pkg::PROD_W - tpe_pkg::LO_W){1'b0}}, lo_s2[d]});
			sum_c[d]  = $signed({full_c[d][tpe_pkg::PROD_W-1],
				full_c[d][tpe_pkg::PROD_W-1:tpe_pkg::FRAC_SHIFT]})
				+ $signed({{(tpe_pkg::SUM_W - tpe_pkg::WC_W){wc_s2[d][tpe_pkg::WC_W-1]}},
				wc_s2[d]});
			clamp_c[d] = (sum_c[d][tpe_pkg::SUM_W-1:tpe_pkg::VAL_W-1] != '0)
				&& (sum_c[d][tpe_pkg::SUM_W-1:tpe_pkg::VAL_W-1] != '1);
			if (clamp_c[d]) begin
				new_c[d] = sum_c[d][tpe_pkg::SUM_W-1] ? tpe_pkg::VAL_MIN : tpe_pkg::VAL_MAX;
			end else begin
				new_c[d] = sum_c[d][tpe_pkg::VAL_W-1:0];
			end
			// lane d only runs for powers at or above its derivative order
			en_c[d] = int'(j_s2) >= d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int d = 0; d < tpe_pkg::NUM_DER; d++) begin
				for (int a = 0; a < tpe_pkg::NUM_AXES; a++) begin
					acc_q[d][a] <= '0;
				end
			end
		end else if (vld_s2) begin
			for (int d = 0; d < tpe_pkg::NUM_DER; d++) begin
				if (en_c[d]) begin
					acc_q[d][axis_s2] <= new_c[d];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.capture) begin
			sat_q <= 1'b0;
		end else if (vld_s2 && ((clamp_c & en_c) != '0)) begin
			sat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q     <= acc_q;
			res_sat_q <= sat_q;
		end
	end

	assign res_val = res_q;
	assign res_sat = res_sat_q;

endmodule

// ===== dv/tpe_motion_checker.sv =====
// checker of the trajectory polynomial evaluator: mirrors the coefficient table and predicts each sample
module tpe_motion_checker (
	input  logic clk,
	input  logic arst_n,
	tpe_req_if   req,
	tpe_res_if   res,
	output int   mismatches,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tpe_pkg::*;

	localparam int NUM_VALUES = NUM_AXES * NUM_DER;

	typedef struct {
		val_t value [NUM_VALUES];
		logic clamped;
	} motion_sample_t;

	val_t           coeff_table [SEGMENTS][NUM_AXES][COEFFS];
	motion_sample_t expected_samples [$];
	int             fail_count = 0;
	string          field_names [NUM_VALUES] = '{"pos_x", "pos_y", "pos_z",
		"vel_x", "vel_y", "vel_z", "acc_x", "acc_y", "acc_z"};

	assign mismatches = fail_count;
	assign pending    = expected_samples.size();

	// horner sum of derivative order d; every step floors the time product and clamps
	function automatic val_t horner_sum(input int seg, input int ax, input int d,
			input logic [TIME_W-1:0] t, inout logic clamped);
		logic signed [79:0] acc;
		logic signed [79:0] t_wide;
		int w;
		acc = '0;
		t_wide = {56'd0, t};
		for (int j = COEFFS - 1; j >= d; j--) begin
			w = (d == 0) ? 1 : (d == 1) ? j : j * (j - 1);
			acc = ((acc * t_wide) >>> FRAC_SHIFT) + w * coeff_table[seg][ax][j];
			if (acc > VAL_MAX) begin
				acc = VAL_MAX;
				clamped = 1'b1;
			end else if (acc < VAL_MIN) begin
				acc = VAL_MIN;
				clamped = 1'b1;
			end
		end
		return acc[VAL_W-1:0];
	endfunction

	function automatic motion_sample_t predict_motion(input logic [SEG_W-1:0] seg,
			input logic [TIME_W-1:0] t);
		motion_sample_t s;
		s.clamped = 1'b0;
		for (int k = 0; k < NUM_VALUES; k++) begin
			s.value[k] = '0;
		end
		if (seg < SEGMENTS) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				for (int d = 0; d < NUM_DER; d++) begin
					s.value[d * NUM_AXES + a] = horner_sum(seg, a, d, t, s.clamped);
				end
			end
		end
		return s;
	endfunction

	always @(posedge clk) begin
		motion_sample_t seen;
		motion_sample_t want;
		if (arst_n) begin
			// results first: a result at this edge belongs to an older request
			if (res.valid && res.ready) begin
				seen.value = '{res.pos_x, res.pos_y, res.pos_z, res.vel_x, res.vel_y,
					res.vel_z, res.acc_x, res.acc_y, res.acc_z};
				seen.clamped = res.saturated;
				if (expected_samples.size() == 0) begin
					$error("result with no evaluate request outstanding");
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					for (int k = 0; k < NUM_VALUES; k++) begin
						if (seen.value[k] !== want.value[k]) begin
							$error("%s: expected %0d, got %0d", field_names[k],
								want.value[k], seen.value[k]);
							fail_count++;
						end
					end
					if (seen.clamped !== want.clamped) begin
						$error("saturated: expected %0b, got %0b", want.clamped,
							seen.clamped);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_WRITE) begin
					if (req.segment < SEGMENTS && req.axis < NUM_AXES && req.power < COEFFS) begin
						coeff_table[req.segment][req.axis][req.power] = req.coeff_value;
					end
				end else begin
					expected_samples.push_back(predict_motion(req.segment, req.time_value));
				end
			end
		end
	end

endmodule

// ===== dv/tb_trajectory_polynomial_evaluator.sv =====
// testbench top of the trajectory polynomial evaluator: stimulus, result back-pressure and verdict
module tb_trajectory_polynomial_evaluator;
	timeunit 1ns;
	timeprecision 1ps;

	import tpe_pkg::*;

	localparam int TOTAL_ITEMS   = 1400;
	localparam int STALL_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 300;
	localparam int ENTRY_COUNT   = NUM_AXES * COEFFS;

	localparam val_t              ONE_Q16_32 = 48'sh0001_0000_0000;
	localparam logic [TIME_W-1:0] T_ZERO     = '0;
	localparam logic [TIME_W-1:0] T_LSB      = 24'h000001;
	localparam logic [TIME_W-1:0] T_HALF     = 24'h008000;
	localparam logic [TIME_W-1:0] T_ONE      = 24'h010000;
	localparam logic [TIME_W-1:0] T_MAX      = '1;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   pending_count;
	int   accepted_items = 0;
	int   idle_cycles = 0;
	logic stream_steady = 1'b0;
	logic hold_done = 1'b0;
	logic [ENTRY_COUNT-1:0] written [SEGMENTS];

	tpe_req_if req_ch ();
	tpe_res_if res_ch ();

	trajectory_polynomial_evaluator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	tpe_motion_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.res        (res_ch),
		.mismatches (mismatch_count),
		.pending    (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic val_t random_coeff(input int max_bits);
		longint raw;
		int bits;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			return VAL_MAX;
		end else if (pick < 8) begin
			return VAL_MIN;
		end
		bits = $urandom_range(1, max_bits);
		raw = {$urandom, $urandom};
		raw = (raw <<< (64 - bits)) >>> (64 - bits);
		return raw[VAL_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] random_time();
		int pick;
		int bits;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			return T_ZERO;
		end else if (pick < 8) begin
			return T_MAX;
		end else if (pick < 12) begin
			return T_ONE;
		end
		bits = $urandom_range(1, TIME_W);
		return TIME_W'($urandom) & ({TIME_W{1'b1}} >> (TIME_W - bits));
	endfunction

	function automatic int pick_gap();
		int pick;
		if (stream_steady) begin
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// offer one request and hold it until the block takes it
	task automatic put_request(input logic kind, input logic [SEG_W-1:0] seg,
			input logic [AXIS_W-1:0] ax, input logic [POW_W-1:0] pw, input val_t cv,
			input logic [TIME_W-1:0] tv);
		int gap;
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.segment     <= seg;
		req_ch.axis        <= ax;
		req_ch.power       <= pw;
		req_ch.coeff_value <= cv;
		req_ch.time_value  <= tv;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (kind == REQ_EVAL) begin
			accepted_items++;
		end else if (ax < NUM_AXES) begin
			written[seg][ax * COEFFS + pw] = 1'b1;
			accepted_items++;
		end
		if ($urandom_range(0, 99) == 0) begin
			stream_steady = !stream_steady;
		end
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_coeff(input logic [SEG_W-1:0] seg, input logic [AXIS_W-1:0] ax,
			input logic [POW_W-1:0] pw, input val_t cv);
		put_request(REQ_WRITE, seg, ax, pw, cv, random_time());
	endtask

	task automatic evaluate(input logic [SEG_W-1:0] seg, input logic [TIME_W-1:0] t);
		put_request(REQ_EVAL, seg, AXIS_W'($urandom_range(0, 3)), POW_W'($urandom),
			random_coeff(VAL_W), t);
	endtask

	initial begin
		int pick;
		int full_segs [$];
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_WRITE;
		req_ch.segment     <= '0;
		req_ch.axis        <= '0;
		req_ch.power       <= '0;
		req_ch.coeff_value <= '0;
		req_ch.time_value  <= '0;
		arst_n <= 1'b0;
		for (int s = 0; s < SEGMENTS; s++) begin
			written[s] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// segment 0: x all at the top, y all at the bottom, z all 1.0
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int p = 0; p < COEFFS; p++) begin
				write_coeff(SEG_W'(0), AXIS_W'(a), POW_W'(p),
					(a == 0) ? VAL_MAX : (a == 1) ? VAL_MIN : ONE_Q16_32);
			end
		end
		evaluate(SEG_W'(0), T_ZERO);
		evaluate(SEG_W'(0), T_LSB);
		evaluate(SEG_W'(0), T_ONE);
		evaluate(SEG_W'(0), T_MAX);
		// write to the missing fourth axis must leave the table untouched
		write_coeff(SEG_W'(0), AXIS_W'(NUM_AXES), POW_W'(0), VAL_MIN);
		// small negative top coefficient checks rounding toward minus infinity
		write_coeff(SEG_W'(0), AXIS_W'(2), POW_W'(COEFFS - 1), -48'sd1);
		evaluate(SEG_W'(0), T_HALF);

		while (accepted_items < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 99);
			full_segs.delete();
			for (int s = 0; s < SEGMENTS; s++) begin
				if (&written[s]) begin
					full_segs.push_back(s);
				end
			end
			if (pick < 45) begin
				evaluate(SEG_W'(full_segs[$urandom_range(0, full_segs.size() - 1)]),
					random_time());
			end else if (pick < 80) begin
				write_coeff(SEG_W'($urandom), AXIS_W'($urandom_range(0, NUM_AXES - 1)),
					POW_W'($urandom), random_coeff(VAL_W));
			end else if (pick < 85) begin
				write_coeff(SEG_W'($urandom), AXIS_W'(NUM_AXES), POW_W'($urandom),
					random_coeff(VAL_W));
			end else begin
				// whole segment, higher powers smaller so that not every sample clamps
				pick = $urandom_range(0, SEGMENTS - 1);
				for (int a = 0; a < NUM_AXES; a++) begin
					for (int p = 0; p < COEFFS; p++) begin
						write_coeff(SEG_W'(pick), AXIS_W'(a), POW_W'(p),
							random_coeff(VAL_W - 5 * p));
					end
				end
			end
		end
		req_ch.valid <= 1'b0;
		// let the checker log the last request before looking at its count
		@(posedge clk);

		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// result back-pressure, with one long hold so the block fills and stalls requests
	initial begin
		int pick;
		int n;
		logic level;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && accepted_items > HOLD_AFTER) begin
				level = 1'b0;
				n = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					level = 1'b1;
					n = $urandom_range(1, 20);
				end else if (pick < 65) begin
					level = 1'b1;
					n = $urandom_range(50, 150);
				end else if (pick < 93) begin
					level = 1'b0;
					n = $urandom_range(1, 4);
				end else begin
					level = 1'b0;
					n = $urandom_range(15, 60);
				end
			end
			res_ch.ready <= level;
			repeat (n) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule
